// ----- hdl/keyed_table_byte_cipher_top_defines.svh -----
// Assertion macros used by the keyed table byte cipher controller.
// Each macro expects clock aclk and active-low reset aresetn in scope.
`ifndef KEYED_TABLE_BYTE_CIPHER_TOP_DEFINES_SVH
`define KEYED_TABLE_BYTE_CIPHER_TOP_DEFINES_SVH

// Check that a condition or implication holds at every clock edge outside reset.
`define KTBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define KTBC_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ktbc_pkg.sv -----
// Shared types and constants for the keyed table byte cipher.
// No dependencies; used by every module of the block except ktbc_ram.
`default_nettype none
package ktbc_pkg;

    localparam int BYTE_W      = 8;
    localparam int KEY_MAX_DEF = 256;
    localparam int KEY_LEN_W   = 9;
    localparam int KEY_LEN_RST = 16;
    localparam int TBL_DEPTH   = 65536;
    localparam int TBL_AW      = 16;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int S_DATA_W    = 56;
    localparam int M_DATA_W    = 8;

    // Bit offsets of the fields inside s_tdata
    localparam int OFS_DATA_BYTE   = 0;
    localparam int OFS_POSITION    = 8;
    localparam int OFS_TABLE_INDEX = 16;
    localparam int OFS_TABLE_VALUE = 32;
    localparam int OFS_KEY_INDEX   = 40;
    localparam int OFS_KEY_VALUE   = 48;

    // Item kinds carried on s_tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_DATA  = 2'd0,
        KIND_TABLE = 2'd1,
        KIND_KEY   = 2'd2
    } kind_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LENGTH   = 1'b0,
        CFG_DECRYPT_MODE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROUND,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;     // data item accepted, begin rounds
        logic round;     // run one round
        logic finish;    // load result into output register
        logic load_tbl;  // table entry write
        logic load_key;  // key byte write
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic zero_rounds; // effective key length is zero
        logic last_round;  // current round is the final one
    } status_t;

endpackage
`default_nettype wire

// ----- hdl/keyed_table_byte_cipher_top.sv -----
// Keyed table byte cipher, top level. Rounds n = min(key_length, KEY_MAX).
// Data item: after acceptance the block runs n rounds, then loads the output register and raises
// m_tvalid once any pending result is taken; only then is the next item accepted.
// Each round is one table memory read whose address depends on the previous read.
// Load items (table entry, key byte) are taken one per cycle while idle; cfg writes are always ready.
// aresetn (synchronous) clears control state and config; key and table memories are not cleared.
`default_nettype none
module keyed_table_byte_cipher_top #(
    parameter int KEY_MAX = ktbc_pkg::KEY_MAX_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // data_byte[7:0], position[15:8], table_index[31:16], table_value[39:32],
    // key_index[47:40], key_value[55:48]
    input  wire logic [ktbc_pkg::S_DATA_W-1:0]    s_tdata,
    // kind[1:0]
    input  wire logic [ktbc_pkg::KIND_W-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_byte[7:0]
    output logic      [ktbc_pkg::M_DATA_W-1:0]    m_tdata,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [ktbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ktbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    ktbc_pkg::cmd_t    cmd;
    ktbc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    ktbc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ktbc_dp #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_byte  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- hdl/ktbc_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none
module ktbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ----- hdl/ktbc_dp.sv -----
// Datapath: configuration registers, key and table memories, round arithmetic.
// Depends on ktbc_pkg and ktbc_ram; driven by ktbc_ctrl commands.
`default_nettype none
module ktbc_dp #(
    parameter int KEY_MAX = ktbc_pkg::KEY_MAX_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire ktbc_pkg::cmd_t                   cmd,
    output ktbc_pkg::status_t                     status,
    input  wire logic [ktbc_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire logic                             cfg_we,
    input  wire logic [ktbc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ktbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic      [ktbc_pkg::M_DATA_W-1:0]    out_byte
);

    localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CW = $clog2(KEY_MAX + 1);
    localparam logic [ktbc_pkg::KEY_LEN_W-1:0] KMAX = ktbc_pkg::KEY_LEN_W'(KEY_MAX);
    localparam int BW = ktbc_pkg::BYTE_W;

    // Input fields
    logic [BW-1:0]               in_data;
    logic [BW-1:0]               in_pos;
    logic [ktbc_pkg::TBL_AW-1:0] in_tbl_idx;
    logic [BW-1:0]               in_tbl_val;
    logic [BW-1:0]               in_key_idx;
    logic [BW-1:0]               in_key_val;

    assign in_data    = s_tdata[ktbc_pkg::OFS_DATA_BYTE   +: BW];
    assign in_pos     = s_tdata[ktbc_pkg::OFS_POSITION    +: BW];
    assign in_tbl_idx = s_tdata[ktbc_pkg::OFS_TABLE_INDEX +: ktbc_pkg::TBL_AW];
    assign in_tbl_val = s_tdata[ktbc_pkg::OFS_TABLE_VALUE +: BW];
    assign in_key_idx = s_tdata[ktbc_pkg::OFS_KEY_INDEX   +: BW];
    assign in_key_val = s_tdata[ktbc_pkg::OFS_KEY_VALUE   +: BW];

    logic [ktbc_pkg::KEY_LEN_W-1:0] key_length_reg;
    logic                           decrypt_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_length_reg <= ktbc_pkg::KEY_LEN_W'(ktbc_pkg::KEY_LEN_RST);
            decrypt_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (ktbc_pkg::cfg_idx_t'(cfg_index))
                ktbc_pkg::CFG_KEY_LENGTH:   key_length_reg <= cfg_data;
                ktbc_pkg::CFG_DECRYPT_MODE: decrypt_reg    <= cfg_data[0];
                default:                    decrypt_reg    <= decrypt_reg;
            endcase
        end
    end

    // Effective round count, saturated at the key store depth
    logic [ktbc_pkg::KEY_LEN_W-1:0] n_sat;
    logic [CW-1:0]                  n_rounds;
    logic [KW-1:0]                  start_addr;

    assign n_sat      = (key_length_reg > KMAX) ? KMAX : key_length_reg;
    assign n_rounds   = n_sat[CW-1:0];
    assign start_addr = decrypt_reg ? KW'(n_sat - ktbc_pkg::KEY_LEN_W'(1)) : '0;

    // Per-item state
    logic [BW-1:0] data_reg;
    logic [BW-1:0] pos_reg;
    logic          dec_reg;
    logic          first_reg;
    logic [CW-1:0] rem_reg;
    logic [KW-1:0] kaddr_reg;
    logic [KW-1:0] kaddr_next;
    logic [BW-1:0] out_reg;

    logic [BW-1:0] key_rd;
    logic [BW-1:0] tbl_rd;
    logic [BW-1:0] cur;
    logic [BW-1:0] entry;

    // Current value: the input before the first round, else the last lookup, less the position when decrypting
    assign cur   = first_reg ? data_reg : (dec_reg ? tbl_rd - pos_reg : tbl_rd);
    assign entry = dec_reg ? cur : cur + pos_reg;
    assign kaddr_next = dec_reg ? kaddr_reg - KW'(1) : kaddr_reg + KW'(1);

    // Round counter and first-round flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b0;
            rem_reg   <= '0;
        end else if (cmd.start) begin
            first_reg <= 1'b1;
            rem_reg   <= n_rounds;
        end else if (cmd.round) begin
            first_reg <= 1'b0;
            rem_reg   <= rem_reg - CW'(1);
        end
    end

    // Item payload and key address
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            data_reg  <= in_data;
            pos_reg   <= in_pos;
            dec_reg   <= decrypt_reg;
            kaddr_reg <= start_addr;
        end else if (cmd.round) begin
            kaddr_reg <= kaddr_next;
        end
        if (cmd.finish) begin
            out_reg <= cur;
        end
    end

    // Key memory: prefetch the key byte one round ahead
    logic          key_we;
    logic [KW-1:0] key_raddr;

    assign key_we    = cmd.load_key && ({1'b0, in_key_idx} < KMAX);
    assign key_raddr = cmd.start ? start_addr : kaddr_next;

    ktbc_ram #(
        .WIDTH (BW),
        .DEPTH (KEY_MAX),
        .AW    (KW)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (KW'(in_key_idx)),
        .wdata (in_key_val),
        .re    (cmd.start | cmd.round),
        .raddr (key_raddr),
        .rdata (key_rd)
    );

    // Table memory: one lookup per round
    ktbc_ram #(
        .WIDTH (BW),
        .DEPTH (ktbc_pkg::TBL_DEPTH),
        .AW    (ktbc_pkg::TBL_AW)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (cmd.load_tbl),
        .waddr (in_tbl_idx),
        .wdata (in_tbl_val),
        .re    (cmd.round),
        .raddr ({key_rd, entry}),
        .rdata (tbl_rd)
    );

    assign status.zero_rounds = (n_rounds == '0);
    assign status.last_round  = (rem_reg == CW'(1));
    assign out_byte           = out_reg;

endmodule
`default_nettype wire

// ----- hdl/ktbc_ctrl.sv -----
// Controller state machine: item handshake, round sequencing, output register valid.
// Depends on ktbc_pkg and the assertion macro header.
`default_nettype none
`include "keyed_table_byte_cipher_top_defines.svh"
module ktbc_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [ktbc_pkg::KIND_W-1:0]   s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    input  wire ktbc_pkg::status_t             status,
    output ktbc_pkg::cmd_t                     cmd
);

    ktbc_pkg::state_t state_reg;
    ktbc_pkg::state_t state_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ktbc_pkg::S_IDLE: begin
                if (cmd.start) begin
                    state_next = status.zero_rounds ? ktbc_pkg::S_DONE : ktbc_pkg::S_ROUND;
                end
            end
            ktbc_pkg::S_ROUND: begin
                if (status.last_round) begin
                    state_next = ktbc_pkg::S_DONE;
                end
            end
            ktbc_pkg::S_DONE: begin
                if (cmd.finish) begin
                    state_next = ktbc_pkg::S_IDLE;
                end
            end
            default: state_next = ktbc_pkg::S_IDLE;
        endcase
    end

    // Outputs and commands
    always_comb begin
        s_tready     = (state_reg == ktbc_pkg::S_IDLE);
        cmd.start    = 1'b0;
        cmd.load_tbl = 1'b0;
        cmd.load_key = 1'b0;
        cmd.round    = (state_reg == ktbc_pkg::S_ROUND);
        cmd.finish   = (state_reg == ktbc_pkg::S_DONE) && (!m_valid_reg || m_tready);
        if (accept) begin
            case (ktbc_pkg::kind_t'(s_tuser))
                ktbc_pkg::KIND_DATA:  cmd.start    = 1'b1;
                ktbc_pkg::KIND_TABLE: cmd.load_tbl = 1'b1;
                ktbc_pkg::KIND_KEY:   cmd.load_key = 1'b1;
                default:              cmd.start    = 1'b0;
            endcase
        end
    end

    // Hold the result until taken
    assign m_valid_next = cmd.finish ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ktbc_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    `KTBC_ASSERT(a_no_overwrite, !(cmd.finish && m_tvalid && !m_tready), "pending result overwritten")
    `KTBC_ASSERT_NEXT(a_finish_valid, cmd.finish, m_tvalid, "finished item not presented")
    `KTBC_ASSERT_NEXT(a_last_done, cmd.round && status.last_round, state_reg == ktbc_pkg::S_DONE, "rounds overran")
    `KTBC_ASSERT(a_busy_no_accept, (cmd.round || cmd.finish) |-> !accept, "item accepted while busy")

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for keyed_table_byte_cipher_top: loads tables and key,
// runs a directed table and random traffic, and checks every output byte.
// Depends on ktbc_pkg and the keyed_table_byte_cipher_top RTL only.
`default_nettype none
module tb;
    import ktbc_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int ROUND_CAP   = KEY_MAX_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam int SEGMENTS    = 6;
    localparam int SEG_ITEMS   = 28;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        data_byte;
        logic [7:0]        position;
        logic [15:0]       table_index;
        logic [7:0]        table_value;
        logic [7:0]        key_index;
        logic [7:0]        key_value;
    } cipher_item_t;

    // One directed row: key length and mode to run it under, the item,
    // and an output byte typed in where it is obvious.
    typedef struct packed {
        logic [8:0]   klen;
        logic         dec;
        cipher_item_t item;
        logic         known;
        logic [7:0]   want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    keyed_table_byte_cipher_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Cipher mirror: key slots, tables and the two registers
    logic [7:0] key_mem [256];
    logic [7:0] tbl_mem [65536];
    logic [8:0] klen_q = 9'd16;
    logic       dec_q  = 1'b0;
    logic [7:0] expected_bytes [$];

    int send_idle = 6;
    int recv_idle = 87;
    int fail_count = 0;
    int stall_cycles = 0;

    // Tables that get fully loaded; every key byte points at one of them
    logic [7:0] loaded_tables [2] = '{8'h00, 8'hFF};

    dir_row_t dir_rows [21] = '{
        // klen  dec   kind         data   pos    tidx      tval   kidx   kval   known  want
        '{9'd0,   1'b0, {KIND_DATA,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00},
        '{9'd0,   1'b0, {KIND_DATA,   8'hFF, 8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, 8'hFF},
        '{9'd0,   1'b1, {KIND_DATA,   8'hA5, 8'h3C, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b1, 8'hA5},
        '{9'd0,   1'b0, {KIND_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 8'h00},
        '{9'd1,   1'b0, {KIND_DATA,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd1,   1'b0, {KIND_DATA,   8'hFF, 8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd1,   1'b1, {KIND_DATA,   8'h80, 8'h01, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd16,  1'b0, {KIND_TABLE,  8'h00, 8'h00, 16'hFF00, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd16,  1'b0, {KIND_DATA,   8'h55, 8'h7F, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd16,  1'b0, {KIND_KEY,    8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'hFF}, 1'b0, 8'h00},
        '{9'd16,  1'b0, {KIND_DATA,   8'h01, 8'hFE, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd16,  1'b1, {KIND_DATA,   8'h01, 8'hFE, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd256, 1'b0, {KIND_DATA,   8'hAA, 8'h55, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd256, 1'b1, {KIND_DATA,   8'h55, 8'hAA, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd511, 1'b0, {KIND_DATA,   8'h3C, 8'hC3, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd511, 1'b1, {KIND_DATA,   8'hC3, 8'h3C, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd257, 1'b0, {KIND_DATA,   8'h00, 8'h80, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd16,  1'b0, {KIND_TABLE,  8'h00, 8'h00, 16'hFFFF, 8'hFF, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd16,  1'b0, {KIND_KEY,    8'h00, 8'h00, 16'h0000, 8'h00, 8'hFF, 8'h00}, 1'b0, 8'h00},
        '{9'd256, 1'b0, {KIND_DATA,   8'hFF, 8'hFF, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00},
        '{9'd256, 1'b1, {KIND_DATA,   8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00}
    };

    // 10 time unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run all rounds of one data byte under the current key length and mode
    function automatic logic [7:0] cipher_byte(input logic [7:0] din, input logic [7:0] pos);
        logic [7:0] v;
        logic [7:0] entry;
        int         n;
        int         i;
        v = din;
        n = (int'(klen_q) > ROUND_CAP) ? ROUND_CAP : int'(klen_q);
        if (!dec_q) begin
            for (i = 0; i < n; i++) begin
                entry = v + pos;
                v = tbl_mem[{key_mem[i], entry}];
            end
        end else begin
            for (i = n; i > 0; i--)
                v = tbl_mem[{key_mem[i-1], v}] - pos;
        end
        return v;
    endfunction

    function automatic logic [7:0] pick_table();
        return loaded_tables[$urandom_range(1)];
    endfunction

    // Random item: mostly data bytes, some table and key rewrites, a little noise
    function automatic cipher_item_t rand_item();
        cipher_item_t it;
        int           roll;
        it = {KIND_DATA, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom)};
        roll = $urandom_range(99);
        if (roll >= 95) begin
            it.kind = KIND_UNUSED;
        end else if (roll >= 88) begin
            it.kind = KIND_KEY;
            it.key_value = pick_table();
        end else if (roll >= 80) begin
            it.kind = KIND_TABLE;
            it.table_index = {pick_table(), 8'($urandom)};
        end
        return it;
    endfunction

    task automatic note_failure(input string what, input logic [7:0] want, input logic [7:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch: %s expected %02h got %02h", what, want, got);
    endtask

    // Offer one item after a random gap; update the mirror when it is taken
    task automatic send_item(input cipher_item_t it, input logic known, input logic [7:0] want);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {it.key_value, it.key_index, it.table_value, it.table_index,
                     it.position, it.data_byte};
        do @(posedge aclk); while (!s_tready);
        case (it.kind)
            KIND_DATA: begin
                if (known)
                    expected_bytes = {expected_bytes, want};
                else
                    expected_bytes = {expected_bytes, cipher_byte(it.data_byte, it.position)};
            end
            KIND_TABLE: tbl_mem[it.table_index] = it.table_value;
            KIND_KEY:   key_mem[it.key_index] = it.key_value;
            default: ;
        endcase
    endtask

    // Stop offering items and let every pending byte come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [8:0] klen, input logic dec);
        drain();
        write_reg(CFG_KEY_LENGTH, klen);
        write_reg(CFG_DECRYPT_MODE, {8'd0, dec});
        cfg_valid <= 1'b0;
        klen_q = klen;
        dec_q  = dec;
    endtask

    // Receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Compare each output byte with the oldest pending one
    always @(posedge aclk) begin : out_check
        logic [7:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                note_failure("unexpected output byte", 8'h00, m_tdata);
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want)
                    note_failure("out_byte", want, m_tdata);
            end
        end
    end

    // Abort when no channel moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !aresetn) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        cipher_item_t it;
        logic [8:0]   klen;
        int           roll;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Load the used tables in full and every key slot
        for (int t = 0; t < 2; t++) begin
            for (int e = 0; e < 256; e++) begin
                it = {KIND_TABLE, 8'h00, 8'h00, {loaded_tables[t], 8'(e)}, 8'($urandom),
                      8'h00, 8'h00};
                send_item(it, 1'b0, 8'h00);
            end
        end
        for (int k = 0; k < 256; k++) begin
            it = {KIND_KEY, 8'h00, 8'h00, 16'h0000, 8'h00, 8'(k), pick_table()};
            send_item(it, 1'b0, 8'h00);
        end

        // Directed rows
        foreach (dir_rows[r]) begin
            if (dir_rows[r].klen != klen_q || dir_rows[r].dec != dec_q)
                configure(dir_rows[r].klen, dir_rows[r].dec);
            send_item(dir_rows[r].item, dir_rows[r].known, dir_rows[r].want);
        end

        // Random traffic in three idling phases, new settings per segment
        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 6 : (ph == 1) ? 87 : 0;
            recv_idle = (ph == 0) ? 87 : (ph == 1) ? 6 : 0;
            for (int sg = 0; sg < SEGMENTS; sg++) begin
                roll = $urandom_range(99);
                if (roll < 6)       klen = 9'd0;
                else if (roll < 10) klen = 9'd256;
                else if (roll < 13) klen = 9'd511;
                else if (roll < 16) klen = 9'($urandom_range(257, 510));
                else                klen = 9'($urandom_range(1, 24));
                configure(klen, 1'($urandom));
                repeat (SEG_ITEMS) send_item(rand_item(), 1'b0, 8'h00);
            end
        end

        // Let stray output show up, then report
        drain();
        repeat (300) @(posedge aclk);
        if (expected_bytes.size() != 0)
            note_failure("output byte never arrived", expected_bytes[0], 8'h00);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
